// File: rtl/core/frt_pkg.sv
`default_nettype none
package frt_pkg;

    localparam int FRAGS_PER_MESSAGE_DEF = 8;
    localparam int MESSAGES_DEF          = 4;
    localparam int FRAG_BYTES_DEF        = 32;
    localparam int MAX_RESULTS           = 32;
    localparam logic [31:0] TIMEOUT_RESET = 32'd60;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_QUERY = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_AGE   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_NOSLOT     = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_MISSING    = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] message_id;
        logic [7:0]  frag_num;
        logic [7:0]  total_frags;
        logic [7:0]  frag_length;
        logic [5:0]  byte_index;
        logic [7:0]  data_byte;
        logic [31:0] time_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       complete;
        logic [7:0] frag_count;
        logic       has_frag;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] message;
        logic [7:0]  frag;
        logic [7:0]  total;
        logic [6:0]  length;
        logic [31:0] stamp;
    } t_hdr;

endpackage
`default_nettype wire

// File: rtl/core/frt_hdr_ram.sv
`default_nettype none
module frt_hdr_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire frt_pkg::t_hdr i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output frt_pkg::t_hdr      o_rdata
);
    import frt_pkg::*;

    t_hdr r_mem [DEPTH];
    t_hdr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/core/frt_pay_ram.sv
`default_nettype none
module frt_pay_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/core/frt_cfg.sv
`default_nettype none
module frt_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [31:0]      o_timeout
);
    import frt_pkg::*;

    logic [31:0] r_timeout;

    // single register, every address in the window maps to it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && (paddr == 2'd0 || paddr != 2'd0)) begin
            r_timeout <= pwdata;
        end
    end

    assign prdata    = r_timeout;
    assign pready    = 1'b1;
    assign o_timeout = r_timeout;
endmodule
`default_nettype wire

// File: rtl/core/fragment_reassembly_table.sv
`default_nettype none
// channel   direction  payload      handshake
// input     in         t_in_item    i_in_valid / o_in_stall
// output    out        t_out_item   o_out_valid / i_out_stall
// config    in/out     32-bit reg   psel penable pwrite paddr pwdata prdata pready
//
// One item at a time. Add with a nonzero byte index, a rejected byte zero and an
// unknown op go straight to the result. Add at byte zero, query, read, age and
// clear sweep the header memory, one slot a cycle. A read then streams its bytes
// (payload memory port), each byte passing through S_RDA, S_RDD and S_OUT.
// Reset clears the active bits at once; no clearing pass. A stalled result holds
// and no new item is taken until it is delivered.
module fragment_reassembly_table #(
    parameter int FRAGS_PER_MESSAGE = frt_pkg::FRAGS_PER_MESSAGE_DEF,
    parameter int MESSAGES          = frt_pkg::MESSAGES_DEF,
    parameter int FRAG_BYTES        = frt_pkg::FRAG_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire frt_pkg::t_in_item i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output frt_pkg::t_out_item o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import frt_pkg::*;

    localparam int SLOTS  = FRAGS_PER_MESSAGE * MESSAGES;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int PDEPTH = SLOTS * FRAG_BYTES;
    localparam int PW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int RD_MAX = (FRAG_BYTES < MAX_RESULTS) ? FRAG_BYTES : MAX_RESULTS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_RDD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] FILL_IDLE = 2'd0;
    localparam logic [1:0] FILL_BUSY = 2'd1;
    localparam logic [1:0] FILL_SKIP = 2'd2;

    logic [2:0]       r_state;
    t_in_item         r_in;
    logic [31:0]      r_cutoff;
    logic [SLOTS-1:0] r_active;
    logic [CW-1:0]    r_cnt;
    logic [1:0]       r_fill_state;
    logic [SW-1:0]    r_fill_slot;
    logic [6:0]       r_fill_len;

    logic             r_fnd, r_first, r_inact, r_old;
    logic [SW-1:0]    r_fnd_idx, r_inact_idx, r_old_idx;
    logic [6:0]       r_fnd_len;
    logic [7:0]       r_first_total;
    logic [31:0]      r_old_time;
    logic [CW-1:0]    r_count;

    logic             r_stream;
    logic [SW-1:0]    r_rd_slot;
    logic [5:0]       r_bi;
    logic [6:0]       r_rd_n;

    t_out_item        r_out;
    logic             r_out_valid;
    t_out_item        n_out;

    logic [31:0]      timeout;
    t_hdr             hdr_rd, hdr_wd;
    logic [7:0]       pay_rd;

    logic             acc, late_store, place, pay_we, bad_hdr, rd_go;
    logic [SW-1:0]    fin_slot, scan_j;
    logic [PW-1:0]    pay_waddr, pay_raddr;
    logic [7:0]       pay_wd;
    logic             mm, mf, act, is_comp;
    logic [6:0]       rd_n;

    frt_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_timeout(timeout)
    );

    always_comb begin
        acc      = i_in_valid && (r_state == S_IDLE);
        bad_hdr  = (i_in_item.frag_length == 8'd0)
                || (32'(i_in_item.frag_length) > 32'(FRAG_BYTES))
                || (32'(i_in_item.frag_num) >= 32'(FRAGS_PER_MESSAGE));
        late_store = acc && (i_in_item.op == OP_ADD) && (i_in_item.byte_index != 6'd0)
                  && (r_fill_state == FILL_BUSY)
                  && ({1'b0, i_in_item.byte_index} < r_fill_len);
        fin_slot = r_inact ? r_inact_idx : r_old_idx;
        place    = (r_state == S_FIN) && (r_in.op == OP_ADD) && !r_fnd && (r_inact || r_old);
        pay_we   = late_store || place;
        pay_waddr = late_store
                  ? PW'(32'(r_fill_slot) * FRAG_BYTES + 32'(i_in_item.byte_index))
                  : PW'(32'(fin_slot) * FRAG_BYTES);
        pay_wd   = late_store ? i_in_item.data_byte : r_in.data_byte;
        pay_raddr = PW'(32'(r_rd_slot) * FRAG_BYTES + 32'(r_bi));
        hdr_wd.message = r_in.message_id;
        hdr_wd.frag    = r_in.frag_num;
        hdr_wd.total   = r_in.total_frags;
        hdr_wd.length  = r_in.frag_length[6:0];
        hdr_wd.stamp   = r_in.time_value;
        scan_j = SW'(r_cnt - 1'b1);
        act    = r_active[scan_j];
        mm     = act && (hdr_rd.message == r_in.message_id);
        mf     = mm && (hdr_rd.frag == r_in.frag_num);
        is_comp = r_first && (32'(r_count) >= 32'(r_first_total));
        rd_n   = (32'(r_fnd_len) > 32'(RD_MAX)) ? 7'(RD_MAX) : r_fnd_len;
        rd_go  = (r_in.op == OP_READ) && is_comp && (r_in.frag_num < r_first_total) && r_fnd;
    end

    // result item built for the state that loads r_out
    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                n_out.status = ((i_in_item.op == OP_ADD) && (i_in_item.byte_index != 6'd0)
                               && ((r_fill_state == FILL_SKIP) || late_store))
                             ? ST_OK : ST_INVALID;
            end
            S_FIN: begin
                case (r_in.op)
                    OP_ADD: begin
                        n_out.status = (r_fnd || place) ? ST_OK : ST_NOSLOT;
                    end
                    OP_QUERY: begin
                        n_out.status     = ST_OK;
                        n_out.complete   = is_comp;
                        n_out.frag_count = (32'(r_count) > 32'd255) ? 8'hFF : 8'(r_count);
                        n_out.has_frag   = r_fnd;
                    end
                    OP_READ: begin
                        n_out.status = !is_comp ? ST_INCOMPLETE : ST_MISSING;
                    end
                    default: begin
                        n_out.status = ST_OK;
                    end
                endcase
            end
            S_RDD: begin
                n_out.status   = ST_OK;
                n_out.out_byte = pay_rd;
                n_out.last     = (7'(r_bi) + 7'd1 == r_rd_n);
            end
            default: begin
                n_out = r_out;
            end
        endcase
    end

    frt_hdr_ram #(.DEPTH(SLOTS), .AW(SW)) u_hdr (
        .i_clk, .i_we(place), .i_waddr(fin_slot), .i_wdata(hdr_wd),
        .i_raddr(r_cnt[SW-1:0]), .o_rdata(hdr_rd)
    );

    frt_pay_ram #(.DEPTH(PDEPTH), .AW(PW)) u_pay (
        .i_clk, .i_we(pay_we), .i_waddr(pay_waddr), .i_wdata(pay_wd),
        .i_raddr(pay_raddr), .o_rdata(pay_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_fill_state <= FILL_IDLE;
            r_fill_slot  <= '0;
            r_out_valid  <= 1'b0;
            r_stream     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_in     <= i_in_item;
                        r_cutoff <= i_in_item.time_value - timeout;
                        r_cnt    <= '0;
                        r_fnd    <= 1'b0;
                        r_first  <= 1'b0;
                        r_inact  <= 1'b0;
                        r_old    <= 1'b0;
                        r_count  <= '0;
                        r_out    <= n_out;
                        case (i_in_item.op)
                            OP_ADD: begin
                                if (i_in_item.byte_index != 6'd0) begin
                                    if (late_store
                                        && (7'(i_in_item.byte_index) + 7'd1 == r_fill_len)) begin
                                        r_active[r_fill_slot] <= 1'b1;
                                        r_fill_state <= FILL_IDLE;
                                    end
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_OUT;
                                end else begin
                                    r_fill_state <= FILL_IDLE;
                                    if (bad_hdr) begin
                                        r_out_valid  <= 1'b1;
                                        r_state      <= S_OUT;
                                    end else begin
                                        r_state <= S_SCAN;
                                    end
                                end
                            end
                            OP_QUERY, OP_READ, OP_AGE, OP_CLEAR: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_out_valid  <= 1'b1;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // read of slot r_cnt issued, data of slot r_cnt-1 here
                    if (r_cnt != '0) begin
                        if (mf && !r_fnd) begin
                            r_fnd     <= 1'b1;
                            r_fnd_idx <= scan_j;
                            r_fnd_len <= hdr_rd.length;
                        end
                        if (mm && !r_first) begin
                            r_first       <= 1'b1;
                            r_first_total <= hdr_rd.total;
                        end
                        if (mm) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (!act && !r_inact) begin
                            r_inact     <= 1'b1;
                            r_inact_idx <= scan_j;
                        end
                        if (mm && (!r_old || hdr_rd.stamp < r_old_time)) begin
                            r_old      <= 1'b1;
                            r_old_idx  <= scan_j;
                            r_old_time <= hdr_rd.stamp;
                        end
                        if ((r_in.op == OP_AGE && act && hdr_rd.stamp < r_cutoff)
                            || (r_in.op == OP_CLEAR && mm)) begin
                            r_active[scan_j] <= 1'b0;
                        end
                    end
                    if (r_cnt == CW'(SLOTS)) begin
                        r_state <= S_FIN;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_FIN: begin
                    r_out       <= n_out;
                    r_out_valid <= !rd_go;
                    r_state     <= rd_go ? S_RDA : S_OUT;
                    case (r_in.op)
                        OP_ADD: begin
                            if (r_fnd) begin
                                r_fill_state <= FILL_SKIP;
                            end else if (place) begin
                                r_fill_slot  <= fin_slot;
                                r_fill_len   <= r_in.frag_length[6:0];
                                if (r_in.frag_length == 8'd1) begin
                                    r_active[fin_slot] <= 1'b1;
                                    r_fill_state <= FILL_IDLE;
                                end else begin
                                    r_active[fin_slot] <= 1'b0;
                                    r_fill_state <= FILL_BUSY;
                                end
                            end
                        end
                        OP_READ: begin
                            if (rd_go) begin
                                r_stream    <= 1'b1;
                                r_rd_slot   <= r_fnd_idx;
                                r_rd_n      <= rd_n;
                                r_bi        <= 6'd0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_RDA: begin
                    r_state <= S_RDD;
                end
                S_RDD: begin
                    r_out          <= n_out;
                    r_out_valid    <= 1'b1;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_stream && !r_out.last) begin
                            r_bi    <= r_bi + 6'd1;
                            r_state <= S_RDA;
                        end else begin
                            r_stream <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire
